FILE: src/tcw_pkg.sv
// Shared types and constants for the text console writer.
// Used by tcw_ctrl, tcw_datapath, text_console_writer and the testbench; depends on nothing.
package tcw_pkg;

    // Default screen geometry.
    localparam int DEF_COLUMNS = 80;
    localparam int DEF_ROWS    = 25;

    // Fixed field widths of the stream and configuration ports.
    localparam int OP_W    = 2;
    localparam int CHAR_W  = 8;
    localparam int RADDR_W = 11;
    localparam int POS_W   = 11;
    localparam int CELL_W  = 16;
    localparam int ATTR_W  = 8;

    // Character codes and reset values.
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd31;
    localparam logic [CELL_W-1:0] RESET_BLANK  = {ATTR_RESET, SPACE_CODE};

    // Operation codes carried on the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_PUT   = 2'd0,
        OP_BKSP  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } t_op;

    // Controller states.
    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_P_WRAP,
        ST_P_CHK1,
        ST_P_CHAR,
        ST_P_CHK2,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_SCR_BLANK,
        ST_BKSP,
        ST_CLEAR,
        ST_RD_REQ,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic newline;
        logic put_write;
        logic bksp;
        logic home;
        logic scr_home;
        logic sweep_clr;
        logic sweep_rd;
        logic sweep_copy;
        logic sweep_blank;
        logic init_fill;
        logic read_req;
        logic result_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic col_wrap;
        logic row_full;
        logic at_origin;
        logic is_newline;
        logic copy_end;
        logic sweep_end;
        logic out_stall;
    } t_dp_stat;

endpackage

FILE: src/tcw_ctrl.sv
// Controller state machine of the text console writer.
// Depends on tcw_pkg; drives tcw_datapath through t_dp_cmd and reads t_dp_stat.
module tcw_ctrl
    import tcw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_op      i_op,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state, n_state;
    // Set while the scroll in progress follows a newline, so that it ends the put.
    logic   r_second, n_second;

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_INIT;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    // Next state.
    always_comb begin
        n_state  = r_state;
        n_second = r_second;
        unique case (r_state)
            ST_INIT: begin
                if (i_stat.sweep_end) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_op)
                        OP_PUT:   n_state = ST_P_WRAP;
                        OP_BKSP:  n_state = ST_BKSP;
                        OP_CLEAR: n_state = ST_CLEAR;
                        OP_READ:  n_state = ST_RD_REQ;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_P_WRAP: n_state = ST_P_CHK1;
            ST_P_CHK1: begin
                n_second = 1'b0;
                n_state  = i_stat.row_full ? ST_SCR_RD : ST_P_CHAR;
            end
            ST_P_CHAR: begin
                n_state = i_stat.is_newline ? ST_P_CHK2 : ST_DONE;
            end
            ST_P_CHK2: begin
                n_second = 1'b1;
                n_state  = i_stat.row_full ? ST_SCR_RD : ST_DONE;
            end
            ST_SCR_RD: n_state = ST_SCR_WR;
            ST_SCR_WR: begin
                n_state = i_stat.copy_end ? ST_SCR_BLANK : ST_SCR_RD;
            end
            ST_SCR_BLANK: begin
                if (i_stat.sweep_end) n_state = r_second ? ST_DONE : ST_P_CHAR;
            end
            ST_BKSP:   n_state = ST_DONE;
            ST_CLEAR: begin
                if (i_stat.sweep_end) n_state = ST_DONE;
            end
            ST_RD_REQ: n_state = ST_DONE;
            ST_DONE: begin
                if (!i_stat.out_stall) n_state = ST_IDLE;
            end
            default: n_state = ST_INIT;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_INIT: o_cmd.init_fill = 1'b1;
            ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.sweep_clr = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            ST_P_WRAP: o_cmd.newline = i_stat.col_wrap;
            ST_P_CHK1: o_cmd.sweep_clr = 1'b1;
            ST_P_CHAR: begin
                o_cmd.newline   = i_stat.is_newline;
                o_cmd.put_write = !i_stat.is_newline;
            end
            ST_P_CHK2: o_cmd.sweep_clr = 1'b1;
            ST_SCR_RD: o_cmd.sweep_rd = 1'b1;
            ST_SCR_WR: o_cmd.sweep_copy = 1'b1;
            ST_SCR_BLANK: begin
                o_cmd.sweep_blank = 1'b1;
                o_cmd.scr_home    = i_stat.sweep_end;
            end
            ST_BKSP: o_cmd.bksp = !i_stat.at_origin;
            ST_CLEAR: begin
                o_cmd.sweep_blank = 1'b1;
                o_cmd.home        = i_stat.sweep_end;
            end
            ST_RD_REQ: o_cmd.read_req = 1'b1;
            ST_DONE: o_cmd.result_load = !i_stat.out_stall;
            default: o_cmd = '0;
        endcase
    end

endmodule

FILE: src/tcw_datapath.sv
// Datapath of the text console writer: cell store, cursor, sweep counter,
// attribute register and output register. Depends on tcw_pkg; driven by tcw_ctrl.
module tcw_datapath
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  t_op                i_op,
    input  logic [CHAR_W-1:0]  i_char,
    input  logic [RADDR_W-1:0] i_raddr,
    input  logic               i_cfg_wen,
    input  logic [ATTR_W-1:0]  i_cfg_wdata,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [POS_W-1:0]   o_out_pos,
    output logic [CELL_W-1:0]  o_out_cell
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int AW     = $clog2(CELLS);
    localparam int PW     = $clog2(CELLS + 1);
    localparam int RW     = $clog2(ROWS + 1);
    localparam int CW     = $clog2(COLUMNS + 1);
    localparam int XW     = (AW > RADDR_W) ? AW : RADDR_W;
    localparam int PXW    = (PW > POS_W) ? PW : POS_W;

    logic [CELL_W-1:0]  r_mem [CELLS];
    logic [CELL_W-1:0]  r_rdata;
    logic [RW-1:0]      r_row;
    logic [CW-1:0]      r_col;
    logic [AW-1:0]      r_cnt;
    logic [ATTR_W-1:0]  r_attr;
    t_op                r_op;
    logic [CHAR_W-1:0]  r_char;
    logic [RADDR_W-1:0] r_addr;
    logic               r_out_valid;
    logic [POS_W-1:0]   r_out_pos;
    logic [CELL_W-1:0]  r_out_cell;

    logic [PW-1:0]      pos_full;
    logic [PW-1:0]      pos_m1;
    logic [PXW-1:0]     pos_x;
    logic [XW-1:0]      addr_x;
    logic               in_range;
    logic [CELL_W-1:0]  blank;
    logic               we;
    logic [AW-1:0]      waddr;
    logic [CELL_W-1:0]  wdata;
    logic               re;
    logic [AW-1:0]      raddr;

    // Cursor as a linear cell index; the row is below ROWS whenever it is used.
    assign pos_full = PW'(r_row) * PW'(COLUMNS) + PW'(r_col);
    assign pos_m1   = pos_full - PW'(1);
    assign pos_x    = PXW'(pos_full);
    assign addr_x   = XW'(r_addr);
    assign in_range = addr_x < XW'(CELLS);
    assign blank    = {r_attr, SPACE_CODE};

    // Status towards the controller.
    always_comb begin
        o_stat.col_wrap   = r_col == CW'(COLUMNS);
        o_stat.row_full   = r_row == RW'(ROWS);
        o_stat.at_origin  = (r_row == '0) && (r_col == '0);
        o_stat.is_newline = r_char == NEWLINE_CODE;
        o_stat.copy_end   = r_cnt == AW'((ROWS - 1) * COLUMNS - 1);
        o_stat.sweep_end  = r_cnt == AW'(CELLS - 1);
        o_stat.out_stall  = r_out_valid && !i_out_ready;
    end

    // Write port selection.
    always_comb begin
        we    = 1'b1;
        waddr = r_cnt;
        wdata = blank;
        if (i_cmd.init_fill) begin
            wdata = RESET_BLANK;
        end else if (i_cmd.sweep_blank) begin
            wdata = blank;
        end else if (i_cmd.sweep_copy) begin
            wdata = r_rdata;
        end else if (i_cmd.put_write) begin
            waddr = pos_full[AW-1:0];
            wdata = {r_attr, r_char};
        end else if (i_cmd.bksp) begin
            waddr = pos_m1[AW-1:0];
        end else begin
            we = 1'b0;
        end
    end

    // Read port selection: the scroll reads one row ahead of the write.
    assign re    = i_cmd.sweep_rd || i_cmd.read_req;
    assign raddr = i_cmd.sweep_rd ? AW'(r_cnt + AW'(COLUMNS)) : addr_x[AW-1:0];

    // Cell store with registered read data.
    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (re) r_rdata <= r_mem[raddr];
    end

    // Latched input item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_op;
            r_char <= i_char;
            r_addr <= i_raddr;
        end
    end

    // Attribute register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= ATTR_RESET;
        end else if (i_cfg_wen) begin
            r_attr <= i_cfg_wdata;
        end
    end

    // Sweep counter for the reset fill, clear and scroll.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.sweep_clr) begin
            r_cnt <= '0;
        end else if (i_cmd.init_fill || i_cmd.sweep_blank || i_cmd.sweep_copy) begin
            r_cnt <= r_cnt + AW'(1);
        end
    end

    // Cursor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.home) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.scr_home) begin
            r_row <= RW'(ROWS - 1);
            r_col <= '0;
        end else if (i_cmd.newline) begin
            r_row <= r_row + RW'(1);
            r_col <= '0;
        end else if (i_cmd.put_write) begin
            r_col <= r_col + CW'(1);
        end else if (i_cmd.bksp) begin
            if (r_col == '0) begin
                r_col <= CW'(COLUMNS - 1);
                r_row <= r_row - RW'(1);
            end else begin
                r_col <= r_col - CW'(1);
            end
        end
    end

    // Output register; it holds a result until the transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            r_out_pos  <= pos_x[POS_W-1:0];
            r_out_cell <= ((r_op == OP_READ) && in_range) ? r_rdata : '0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_pos   = r_out_pos;
    assign o_out_cell  = r_out_cell;

endmodule

FILE: src/text_console_writer.sv
// Top level of the text console writer: stream ports and configuration port.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
//
//  Port group   Direction  Carries
//  s_axis_*     in         one operation: tuser = operation, tdata = char and read address
//  m_axis_*     out        one result per operation: cursor position and cell data
//  i_cfg_*      in         attribute byte written into the single register
//
// After reset a clearing pass fills every cell of the store with the reset blank;
// no operation is taken meanwhile, configuration writes are.
// A clear sweeps every cell with the current blank, and each scroll copies the
// rows up one cell at a time, reading and writing in turn, then blanks the bottom
// row, all through the one read port and one write port of the cell store.
// One operation is in progress at a time; the next is taken while a result
// still waits in the output register, and a stall there holds only the finish.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = DEF_COLUMNS,
    parameter int ROWS    = DEF_ROWS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [23:0]        s_axis_tdata,  // [7:0] char_code, [18:8] read_address
    input  logic [OP_W-1:0]    s_axis_tuser,  // [1:0] operation
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [31:0]        m_axis_tdata,  // [10:0] cursor_position, [26:11] cell_data
    input  logic               i_cfg_wen,
    input  logic [ATTR_W-1:0]  i_cfg_wdata
);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    t_op              op;
    logic [POS_W-1:0] out_pos;
    logic [CELL_W-1:0] out_cell;

    assign op = t_op'(s_axis_tuser);

    // Controller.
    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (op),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    // Datapath.
    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (op),
        .i_char      (s_axis_tdata[7:0]),
        .i_raddr     (s_axis_tdata[18:8]),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_pos   (out_pos),
        .o_out_cell  (out_cell)
    );

    // Output packing with zero fill to whole bytes.
    assign m_axis_tdata = {5'd0, out_cell, out_pos};

endmodule

FILE: sim/tb_text_console_writer.sv
// Self-checking testbench for text_console_writer: directed and random console
// operations with a screen predictor and an in-order result check.
// Depends on tcw_pkg and the text_console_writer RTL only.
`timescale 1ns / 100ps

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int SCREEN_COLS  = DEF_COLUMNS;
    localparam int SCREEN_ROWS  = DEF_ROWS;
    localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;
    localparam int MAX_REPORTS  = 10;

    // One expected result transaction: cursor position and cell data.
    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [CELL_W-1:0] cell_data;
    } t_console_result;

    // Screen predictor and the queue of results it has worked out.
    class console_scoreboard;
        logic [CELL_W-1:0] screen [SCREEN_CELLS];
        int                row;
        int                col;
        logic [ATTR_W-1:0] attr;
        t_console_result   expected_results [$];
        int                failures;

        function new();
            attr     = ATTR_RESET;
            row      = 0;
            col      = 0;
            failures = 0;
            fill_blank();
        endfunction

        function logic [CELL_W-1:0] blank_cell();
            return {attr, SPACE_CODE};
        endfunction

        function void fill_blank();
            foreach (screen[i]) screen[i] = blank_cell();
        endfunction

        function int cursor();
            return row * SCREEN_COLS + col;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void set_attribute(logic [ATTR_W-1:0] value);
            attr = value;
        endfunction

        // Every row moves up one; the bottom row is blanked with the current colour.
        function void scroll_up();
            for (int i = 0; i < (SCREEN_ROWS - 1) * SCREEN_COLS; i++)
                screen[i] = screen[i + SCREEN_COLS];
            for (int i = (SCREEN_ROWS - 1) * SCREEN_COLS; i < SCREEN_CELLS; i++)
                screen[i] = blank_cell();
            row = SCREEN_ROWS - 1;
            col = 0;
        endfunction

        // A pending wrap is resolved first, then a newline or a written character.
        function void put_char(logic [CHAR_W-1:0] ch);
            if (col >= SCREEN_COLS) begin
                row++;
                col = 0;
            end
            if (row >= SCREEN_ROWS) scroll_up();
            if (ch == NEWLINE_CODE) begin
                row++;
                col = 0;
                if (row >= SCREEN_ROWS) scroll_up();
            end else begin
                screen[row * SCREEN_COLS + col] = {attr, ch};
                col++;
            end
        endfunction

        // Nothing happens at the origin; at column zero the cursor goes up a row.
        function void back_space();
            int pos;
            pos = cursor();
            if (pos != 0) begin
                screen[pos - 1] = blank_cell();
                if (col == 0) begin
                    col = SCREEN_COLS - 1;
                    row--;
                end else begin
                    col--;
                end
            end
        endfunction

        // Applies one accepted operation and queues the result it must produce.
        function void note_operation(t_op op, logic [CHAR_W-1:0] ch,
                                     logic [RADDR_W-1:0] addr);
            t_console_result res;
            res.cell_data = '0;
            case (op)
                OP_PUT:   put_char(ch);
                OP_BKSP:  back_space();
                OP_CLEAR: begin
                    fill_blank();
                    row = 0;
                    col = 0;
                end
                default: begin
                    if (addr < SCREEN_CELLS) res.cell_data = screen[addr];
                end
            endcase
            res.pos = POS_W'(cursor());
            expected_results.push_back(res);
        endfunction

        // Compares one result transaction with the oldest expectation.
        function void check_result(logic [POS_W-1:0] pos, logic [CELL_W-1:0] cell_data);
            t_console_result want;
            if (expected_results.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: ERROR result with nothing expected: pos %0d cell %h",
                             $time, pos, cell_data);
                return;
            end
            want = expected_results.pop_front();
            if (pos !== want.pos || cell_data !== want.cell_data) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: ERROR pos exp %0d got %0d, cell exp %h got %h",
                             $time, want.pos, pos, want.cell_data, cell_data);
            end
        endfunction
    endclass

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [23:0]         s_axis_tdata  = '0;  // [7:0] char_code, [18:8] read_address
    logic [OP_W-1:0]     s_axis_tuser  = '0;  // [1:0] operation
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [31:0]         m_axis_tdata;        // [10:0] cursor_position, [26:11] cell_data
    logic                i_cfg_wen     = 1'b0;
    logic [ATTR_W-1:0]   i_cfg_wdata   = '0;

    console_scoreboard sb = new();
    bit                idling_on = 1'b1;
    int                items_sent = 0;

    text_console_writer i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Safety net against a hung handshake.
    initial begin
        #250_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side: ready drops in random bursts while idling is enabled.
    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold == 0 && idling_on && $urandom_range(0, 7) == 0)
                hold = $urandom_range(1, 16);
            if (hold > 0) begin
                m_axis_tready <= 1'b0;
                hold--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Every accepted result transaction is checked at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[10:0], m_axis_tdata[26:11]);
    end

    // Offers one operation, optionally after an idle burst, and waits for it to be taken.
    // Entered and left at a falling edge; valid stays high for a following operation.
    task automatic send_op(input t_op op, input logic [CHAR_W-1:0] ch,
                           input logic [RADDR_W-1:0] addr);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'b0, addr, ch};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_operation(op, ch, addr);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Holds the sender off until every expected result has arrived.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    // Writes the attribute register; only called while the block is idle.
    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wen   <= 1'b0;
        sb.set_attribute(value);
    endtask

    // Random traffic built from runs of text, newlines, backspaces, reads, clears, drains and noise.
    task automatic random_traffic(input int count);
        int                 target;
        int                 kind;
        int                 len;
        int                 pos;
        logic [CHAR_W-1:0]  ch;
        logic [RADDR_W-1:0] addr;
        target = items_sent + count;
        while (items_sent < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                // Text run, often exactly long enough to leave a wrap pending.
                if ($urandom_range(0, 2) == 0)
                    len = (sb.col < SCREEN_COLS) ? SCREEN_COLS - sb.col : $urandom_range(1, 3);
                else
                    len = $urandom_range(1, 30);
                repeat (len) begin
                    ch = CHAR_W'($urandom_range(0, 255));
                    if (ch == NEWLINE_CODE) ch = SPACE_CODE;
                    send_op(OP_PUT, ch, RADDR_W'($urandom_range(0, 2047)));
                end
                if ($urandom_range(0, 1) == 0)
                    send_op(OP_PUT, NEWLINE_CODE, RADDR_W'($urandom_range(0, 2047)));
            end else if (kind < 55) begin
                repeat ($urandom_range(1, 3))
                    send_op(OP_PUT, NEWLINE_CODE, RADDR_W'($urandom_range(0, 2047)));
            end else if (kind < 70) begin
                // Mostly short rubouts, sometimes long ones that climb rows.
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 100)
                                                  : $urandom_range(1, 6);
                repeat (len) send_op(OP_BKSP, CHAR_W'($urandom_range(0, 255)),
                                     RADDR_W'($urandom_range(0, 2047)));
            end else if (kind < 90) begin
                repeat ($urandom_range(1, 4)) begin
                    pos = sb.cursor();
                    case ($urandom_range(0, 3))
                        0:       addr = RADDR_W'($urandom_range(0, 2047));
                        1:       addr = RADDR_W'($urandom_range(SCREEN_CELLS, 2047));
                        2:       addr = RADDR_W'((pos > 0 && $urandom_range(0, 1)) ? pos - 1
                                                                                : pos);
                        default: addr = RADDR_W'($urandom_range(SCREEN_CELLS - SCREEN_COLS,
                                                                SCREEN_CELLS - 1));
                    endcase
                    send_op(OP_READ, CHAR_W'($urandom_range(0, 255)), addr);
                end
            end else if (kind < 92) begin
                send_op(OP_CLEAR, CHAR_W'($urandom_range(0, 255)),
                        RADDR_W'($urandom_range(0, 2047)));
            end else if (kind < 94) begin
                drain_results();
            end else begin
                send_op(t_op'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                        RADDR_W'($urandom_range(0, 2047)));
            end
        end
    endtask

    // Main sequence: reset, directed cases, then random phases under several colours.
    initial begin : stimulus
        int waited;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed cases with the reset colour.
        send_op(OP_READ, 8'h00, 11'd0);
        send_op(OP_BKSP, 8'h00, 11'd0);           // backspace at the origin
        send_op(OP_PUT, 8'h00, 11'h7FF);
        send_op(OP_PUT, 8'hFF, 11'd0);
        send_op(OP_READ, 8'hFF, 11'd1);
        send_op(OP_PUT, NEWLINE_CODE, 11'd0);
        send_op(OP_BKSP, 8'h00, 11'd0);           // backspace at column zero
        send_op(OP_PUT, 8'h41, 11'd0);            // leaves a wrap pending
        send_op(OP_BKSP, 8'h00, 11'd0);           // backspace with a pending wrap
        send_op(OP_PUT, 8'h42, 11'd0);
        send_op(OP_PUT, 8'h43, 11'd0);            // wraps before writing
        send_op(OP_READ, 8'h00, 11'd79);
        send_op(OP_READ, 8'h00, 11'd80);
        send_op(OP_READ, 8'h00, 11'd1999);
        send_op(OP_READ, 8'h00, 11'd2000);        // reads out of range
        send_op(OP_READ, 8'h00, 11'h7FF);
        send_op(OP_CLEAR, 8'h00, 11'd0);
        send_op(OP_READ, 8'h00, 11'd80);
        send_op(OP_PUT, NEWLINE_CODE, 11'd0);
        send_op(OP_BKSP, 8'h00, 11'd0);
        drain_results();

        // Darkest colour, blanked screen first.
        write_attribute(8'h00);
        send_op(OP_CLEAR, 8'h00, 11'd0);
        random_traffic(350);
        drain_results();

        // Brightest colour without clearing, so old and new colours mix.
        write_attribute(8'hFF);
        random_traffic(350);
        drain_results();

        // Random colour and no idling on either side.
        write_attribute(ATTR_W'($urandom_range(0, 255)));
        idling_on = 1'b0;
        random_traffic(430);

        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 100000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (50) @(negedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
